@@ src/assert_macros.svh @@
// assertion macros shared by the controller and the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define TFI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every rising clock edge, also during reset
`define TFI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/tfi_pkg.sv @@
// types, constants and codes of the thermal factor interpolator
package tfi_pkg;

  localparam int TableDepthDef = 16;
  localparam int MsPerPoll     = 5000;
  localparam int StaleCapMs    = 300000;
  localparam int PollCapS      = StaleCapMs / MsPerPoll;

  localparam logic [15:0] UnityQ12 = 16'd4096;
  localparam logic [19:0] AgeMax   = 20'hFFFFF;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_LOAD   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_ENABLE     = 2'd0,
    CFG_TABLE_SIZE = 2'd1,
    CFG_POLL       = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_ZERO = 3'd1,
    IDX_LAST = 3'd2,
    IDX_ONE  = 3'd3,
    IDX_INC  = 3'd4
  } idx_op_e;

  typedef enum logic [1:0] {
    RES_NONE   = 2'd0,
    RES_UNITY  = 2'd1,
    RES_READ   = 2'd2,
    RES_INTERP = 2'd3
  } res_sel_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] temp_value;
    logic [3:0]         entry_index;
    logic [15:0]        entry_factor;
  } req_t;

  typedef struct packed {
    logic [15:0] factor;
    logic        reading_fresh;
    logic        from_table;
  } res_t;

  typedef struct packed {
    logic     accept;
    logic     cap_fresh;
    idx_op_e  idx_op;
    logic     take_prev;
    res_sel_e res_sel;
    logic     mul_load;
    logic     div_step;
  } cmd_t;

  typedef struct packed {
    logic go;
    logic le_first;
    logic ge_last;
    logic scan_stop;
    logic div_last;
  } sts_t;

endpackage

@@ src/tfi_datapath.sv @@
// datapath: state registers, breakpoint memory, multiplier and serial divider
module tfi_datapath import tfi_pkg::*; #(
  parameter int TableDepth = TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  req_t        req_i,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output res_t        res_o
);

  localparam int IW = $clog2(TableDepth);

  logic               enable_q;
  logic [4:0]         tsize_q;
  logic [11:0]        poll_q;
  logic               has_sample_q;
  logic signed [15:0] held_q;
  logic [19:0]        age_q;

  logic [31:0]        mem_q [TableDepth];
  logic [31:0]        rd_q;
  logic [IW-1:0]      idx_q, idx_d;

  logic signed [15:0] prev_t_q;
  logic [15:0]        prev_f_q;
  logic               neg_q;
  logic [15:0]        rem_q;
  logic [15:0]        dq_q;
  logic [3:0]         cnt_q;

  logic [15:0]        factor_q;
  logic               table_q;
  logic               fresh_q;

  logic [11:0]        poll_eff;
  logic [18:0]        limit;
  logic               fresh;
  int                 n_eff;
  logic [IW-1:0]      nlast;
  logic signed [15:0] rd_t;
  logic [15:0]        rd_f;
  logic signed [16:0] dt;
  logic signed [16:0] df;
  logic [15:0]        dmag;
  logic [31:0]        prod;
  logic [15:0]        den;
  logic [16:0]        trial;
  logic               ge;
  logic [15:0]        interp;

  assign rd_t     = rd_q[31:16];
  assign rd_f     = rd_q[15:0];
  assign poll_eff = (poll_q == 12'd0) ? 12'd1 : poll_q;
  assign limit    = (int'(poll_eff) >= PollCapS) ? 19'(StaleCapMs)
                  : 19'(poll_eff) * 19'(MsPerPoll);
  assign fresh    = has_sample_q && (age_q <= {1'b0, limit});
  assign n_eff    = (int'(tsize_q) > TableDepth) ? TableDepth : int'(tsize_q);
  assign nlast    = IW'(n_eff - 1);

  assign dt     = {held_q[15], held_q} - {prev_t_q[15], prev_t_q};
  assign df     = {1'b0, rd_f} - {1'b0, prev_f_q};
  assign dmag   = df[16] ? 16'(-df) : df[15:0];
  assign prod   = dt[15:0] * dmag;
  assign den    = 16'(rd_t - prev_t_q);
  assign trial  = {rem_q, dq_q[15]} - {1'b0, den};
  assign ge     = {rem_q, dq_q[15]} >= {1'b0, den};
  assign interp = prev_f_q + (neg_q ? (~dq_q + 16'd1) : dq_q);

  assign sts_o.go        = enable_q && fresh && (tsize_q != 5'd0);
  assign sts_o.le_first  = held_q <= rd_t;
  assign sts_o.ge_last   = held_q >= rd_t;
  assign sts_o.scan_stop = (idx_q == nlast) || (rd_t >= held_q);
  assign sts_o.div_last  = &cnt_q;

  always_comb begin
    unique case (cmd_i.idx_op)
      IDX_ZERO: idx_d = '0;
      IDX_LAST: idx_d = nlast;
      IDX_ONE:  idx_d = IW'(1);
      IDX_INC:  idx_d = IW'(idx_q + 1'b1);
      default:  idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      tsize_q  <= 5'd0;
      poll_q   <= 12'd5;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ENABLE:     enable_q <= cfg_data_i[0];
        CFG_TABLE_SIZE: tsize_q  <= cfg_data_i[4:0];
        CFG_POLL:       poll_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_sample_q <= 1'b0;
      held_q       <= '0;
      age_q        <= '0;
    end else if (cmd_i.accept) begin
      unique case (req_i.kind)
        KIND_TICK: begin
          if (age_q != AgeMax) age_q <= age_q + 20'd1;
        end
        KIND_SAMPLE: begin
          held_q       <= req_i.temp_value;
          has_sample_q <= 1'b1;
          age_q        <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && req_i.kind == KIND_LOAD && int'(req_i.entry_index) < TableDepth) begin
      mem_q[IW'(req_i.entry_index)] <= {req_i.temp_value, req_i.entry_factor};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.mul_load) cnt_q <= '0;
      else if (cmd_i.div_step) cnt_q <= cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_prev) begin
      prev_t_q <= rd_t;
      prev_f_q <= rd_f;
    end
    if (cmd_i.mul_load) begin
      neg_q <= df[16];
      rem_q <= prod[31:16];
      dq_q  <= prod[15:0];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? trial[15:0] : {rem_q[14:0], dq_q[15]};
      dq_q  <= {dq_q[14:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_fresh) fresh_q <= fresh;
    unique case (cmd_i.res_sel)
      RES_UNITY: begin
        factor_q <= UnityQ12;
        table_q  <= 1'b0;
      end
      RES_READ: begin
        factor_q <= rd_f;
        table_q  <= 1'b1;
      end
      RES_INTERP: begin
        factor_q <= interp;
        table_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign res_o.factor        = factor_q;
  assign res_o.reading_fresh = fresh_q;
  assign res_o.from_table    = table_q;

endmodule

@@ src/tfi_ctrl.sv @@
// controller: sequences update, breakpoint search, multiply and divide
module tfi_ctrl import tfi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy,
  output logic done_o
);

  `include "assert_macros.svh"

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_EVAL = 9'b000000010,
    ST_RD0  = 9'b000000100,
    ST_RDL  = 9'b000001000,
    ST_SCAN = 9'b000010000,
    ST_MUL  = 9'b000100000,
    ST_DIV  = 9'b001000000,
    ST_FIN  = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign busy   = state_q != ST_IDLE;
  assign done_o = state_q == ST_DONE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{accept: 1'b0, cap_fresh: 1'b0, idx_op: IDX_HOLD, take_prev: 1'b0,
                res_sel: RES_NONE, mul_load: 1'b0, div_step: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.cap_fresh = 1'b1;
        cmd_o.idx_op    = IDX_ZERO;
        if (sts_i.go) begin
          state_d = ST_RD0;
        end else begin
          cmd_o.res_sel = RES_UNITY;
          state_d       = ST_DONE;
        end
      end
      ST_RD0: begin
        if (sts_i.le_first) begin
          cmd_o.res_sel = RES_READ;
          state_d       = ST_DONE;
        end else begin
          cmd_o.take_prev = 1'b1;
          cmd_o.idx_op    = IDX_LAST;
          state_d         = ST_RDL;
        end
      end
      ST_RDL: begin
        if (sts_i.ge_last) begin
          cmd_o.res_sel = RES_READ;
          state_d       = ST_DONE;
        end else begin
          cmd_o.idx_op = IDX_ONE;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_stop) begin
          state_d = ST_MUL;
        end else begin
          cmd_o.take_prev = 1'b1;
          cmd_o.idx_op    = IDX_INC;
        end
      end
      ST_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.res_sel = RES_INTERP;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `TFI_ASSERT(a_done_to_idle, done_o |=> !busy, "result strobe not followed by idle")
  `TFI_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted request did not set busy")
  `TFI_ASSERT(a_div_end, (state_q == ST_DIV && sts_i.div_last) |=> (state_q == ST_FIN),
              "divider did not finish")

endmodule

@@ src/thermal_factor_interpolator.sv @@
// top level of the thermal compensation factor interpolator
//
// request channel: a request is taken at a clock edge with start high and busy
// low; kind selects a millisecond tick, a new temperature sample or a table
// load. every request gives exactly one result on res_o, marked by a one-cycle
// result_valid_o strobe; the receiver cannot hold it off.
// configuration: cfg_valid_i with cfg_index_i (0 enable, 1 table size,
// 2 poll interval) and cfg_data_i; cfg_ready_o is always high. write only
// while busy is low.
// the factor is the 1.0 fallback, the factor of a table end, or otherwise an
// interpolation found by a breakpoint scan over the single memory read port,
// then a multiply and a restoring divide; one request at a time.
// reset clears the sample, its age, enable and table size, and sets the poll
// interval to 5; the breakpoint table is undefined until loaded.
module thermal_factor_interpolator import tfi_pkg::*; #(
  parameter int TableDepth = TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output res_t        res_o,
  output logic        result_valid_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  `include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  tfi_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (result_valid_o)
  );

  tfi_datapath #(
    .TableDepth(TableDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o)
  );

  `TFI_ASSERT(a_stale_unity,
              (result_valid_o && !res_o.reading_fresh) |->
              (res_o.factor == UnityQ12 && !res_o.from_table),
              "stale reading gave a table factor")

endmodule

@@ verif/tb_thermal_factor_interpolator.sv @@
// testbench of the thermal factor interpolator with its own factor predictor
`timescale 1ns / 100ps

module tb_thermal_factor_interpolator;
  import tfi_pkg::*;

  localparam int Depth = 16;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  res_t        res_o;
  logic        result_valid_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [11:0] cfg_data_i;

  thermal_factor_interpolator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .res_o         (res_o),
    .result_valid_o(result_valid_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor state
  logic signed [15:0] bp_temp [Depth];
  logic [15:0]        bp_factor [Depth];
  logic               have_sample;
  logic signed [15:0] last_temp;
  logic [19:0]        age_ms;
  logic               comp_enable;
  logic [4:0]         points_used;
  logic [11:0]        poll_s;

  res_t expected_factors[$];
  int   mismatches;
  int   sender_idle;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic logic [15:0] table_lookup(logic signed [15:0] t, int n);
    int     i;
    longint t0, t1, f0, f1;
    if (t <= bp_temp[0]) return bp_factor[0];
    if (t >= bp_temp[n-1]) return bp_factor[n-1];
    i = 1;
    while (i < n - 1 && bp_temp[i] < t) i++;
    t0 = bp_temp[i-1];
    t1 = bp_temp[i];
    f0 = bp_factor[i-1];
    f1 = bp_factor[i];
    if (t1 <= t0) return 16'((f0 + f1) / 2);
    return 16'(f0 + (longint'(t) - t0) * (f1 - f0) / (t1 - t0));
  endfunction

  function automatic res_t predict_factor(req_t r);
    res_t   o;
    longint limit;
    int     n;
    case (r.kind)
      KIND_TICK: if (age_ms != AgeMax) age_ms = age_ms + 20'd1;
      KIND_SAMPLE: begin
        last_temp   = r.temp_value;
        have_sample = 1'b1;
        age_ms      = '0;
      end
      KIND_LOAD: begin
        bp_temp[r.entry_index]   = r.temp_value;
        bp_factor[r.entry_index] = r.entry_factor;
      end
      default: ;
    endcase
    limit = (poll_s == 0 ? 1 : poll_s) * MsPerPoll;
    if (limit > StaleCapMs) limit = StaleCapMs;
    o.reading_fresh = have_sample && age_ms <= limit;
    n = points_used > Depth ? Depth : points_used;
    o.factor     = UnityQ12;
    o.from_table = 1'b0;
    if (comp_enable && o.reading_fresh && n > 0) begin
      o.factor     = table_lookup(last_temp, n);
      o.from_table = 1'b1;
    end
    return o;
  endfunction

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (expected_factors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_o);
      end else begin
        exp_r = expected_factors.pop_front();
        if (res_o.factor !== exp_r.factor || res_o.reading_fresh !== exp_r.reading_fresh ||
            res_o.from_table !== exp_r.from_table) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, res_o);
        end
      end
    end
  end

  task automatic send_request(logic [1:0] kind, logic signed [15:0] temp,
                              logic [3:0] idx = 0, logic [15:0] fac = 16'd4096);
    req_t r;
    r.kind         = kind;
    r.temp_value   = temp;
    r.entry_index  = idx;
    r.entry_factor = fac;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    expected_factors.insert(expected_factors.size(), predict_factor(r));
    if ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      repeat ($urandom_range(1, $urandom_range(0, 3) == 0 ? 40 : 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_factors.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [11:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ENABLE:     comp_enable = data[0];
      CFG_TABLE_SIZE: points_used = data[4:0];
      CFG_POLL:       poll_s = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_sorted_table();
    int base, step;
    if ($urandom_range(1)) begin
      for (int i = 0; i < Depth; i++)
        send_request(KIND_LOAD, 16'(-32768 + i * 4096 + $urandom_range(0, 4095)), 4'(i),
                     16'($urandom_range(1, 65535)));
    end else begin
      step = $urandom_range(1, 60);
      base = $urandom_range(0, 60000) - 30000;
      for (int i = 0; i < Depth; i++)
        send_request(KIND_LOAD, 16'(base + i * step), 4'(i), 16'($urandom_range(1, 65535)));
    end
  endtask

  task automatic test_reset_values();
    send_request(KIND_TICK, 0);
    send_request(KIND_SAMPLE, 16'sd100);
    wait_drained();
  endtask

  task automatic test_table_interp();
    for (int i = 0; i < Depth; i++)
      send_request(KIND_LOAD, 16'(-32768 + i * 4369), 4'(i), i[0] ? 16'd65535 : 16'd1);
    wait_drained();
    write_reg(CFG_ENABLE, 12'd1);
    write_reg(CFG_TABLE_SIZE, 12'd16);
    write_reg(CFG_POLL, 12'd4095);
    send_request(KIND_SAMPLE, -16'sd32768);
    send_request(KIND_SAMPLE, 16'sd32767);
    send_request(KIND_SAMPLE, 16'(-32768 + 4369));
    send_request(KIND_SAMPLE, 16'sd1000);
    send_request(KIND_SAMPLE, -16'sd1);
    send_request(KIND_UNUSED, 16'sd5, 4'd15, 16'd7);
    send_request(KIND_TICK, 0);
    wait_drained();
    write_reg(CFG_TABLE_SIZE, 12'd31);
    send_request(KIND_SAMPLE, 16'sd12345);
    wait_drained();
    write_reg(CFG_TABLE_SIZE, 12'd1);
    send_request(KIND_SAMPLE, 16'sd12345);
    wait_drained();
    write_reg(CFG_TABLE_SIZE, 12'd0);
    send_request(KIND_SAMPLE, 16'sd12345);
    wait_drained();
    // duplicate breakpoints ahead of the last one in use
    write_reg(CFG_TABLE_SIZE, 12'd4);
    send_request(KIND_LOAD, 16'sd50, 4'd1, 16'd100);
    send_request(KIND_LOAD, 16'sd50, 4'd2, 16'd301);
    send_request(KIND_SAMPLE, 16'sd60);
    send_request(KIND_SAMPLE, 16'sd40);
    wait_drained();
    cfg_index_i <= CFG_UNUSED;
    cfg_data_i  <= 12'hFFF;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    send_request(KIND_SAMPLE, 16'sd60);
    wait_drained();
  endtask

  task automatic test_staleness();
    write_reg(CFG_POLL, 12'd0);
    send_request(KIND_SAMPLE, 16'sd60);
    repeat (20) send_request(KIND_TICK, 16'(-1));
    wait_drained();
    write_reg(CFG_POLL, 12'd1);
    send_request(KIND_TICK, 0);
    wait_drained();
  endtask

  task automatic test_random(int idle_pct, int count);
    int k, pick;
    sender_idle = idle_pct;
    write_reg(CFG_ENABLE, 12'($urandom_range(0, 3) != 0));
    write_reg(CFG_TABLE_SIZE, 12'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : 16));
    write_reg(CFG_POLL, 12'($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                                     : $urandom_range(1, 60)));
    k = 0;
    while (k < count) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        load_sorted_table();
        k += Depth;
      end else begin
        if (pick < 50)
          send_request(KIND_SAMPLE, $urandom_range(0, 7) == 0 ?
                       ($urandom_range(1) ? 16'sd32767 : -16'sd32768) : 16'($urandom));
        else if (pick < 80)
          send_request(KIND_TICK, 16'($urandom), 4'($urandom), 16'($urandom));
        else if (pick < 93)
          send_request(KIND_LOAD, 16'($urandom), 4'($urandom_range(0, 15)),
                       16'($urandom_range(1, 65535)));
        else
          send_request(KIND_UNUSED, 16'($urandom), 4'($urandom), 16'($urandom));
        k++;
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    mismatches  = 0;
    sender_idle = 0;
    for (int i = 0; i < Depth; i++) begin
      bp_temp[i]   = '0;
      bp_factor[i] = '0;
    end
    have_sample = 1'b0;
    last_temp   = '0;
    age_ms      = '0;
    comp_enable = 1'b0;
    points_used = '0;
    poll_s      = 12'd5;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_table_interp();
    test_staleness();
    test_random(30, 600);
    test_random(78, 600);
    test_random(0, 600);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && expected_factors.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
